// ----- rtl/core/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types, command codes and the angle scaler of the servo frame decoder
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int BYTE_W   = 8;
	localparam int FRAME_W  = 56;   // frame bytes 1..7
	localparam int GEAR_W   = 17;
	localparam int EBITS_W  = 5;
	localparam int ANG_W    = 19;
	localparam int CUR_W    = 20;
	localparam int HALF_W   = 16;
	localparam int FLAG_W   = 4;
	localparam int DELTA_W  = 21;
	localparam int PROD_W   = 73;   // count magnitude times gear plus rounding
	localparam int PCNT_W   = 7;
	localparam int REM_W    = 15;
	localparam int MOD_W    = 17;
	localparam int CFG_ADDR_W = 1;

	localparam int FULL_TURN_Q8 = 92160;
	localparam int HALF_TURN_Q8 = 46080;
	localparam int DIVISOR      = 25600;
	localparam int ROUND_HALF   = 12800;

	localparam logic [EBITS_W-1:0] EBITS_RESET = 5'd16;
	localparam logic [GEAR_W-1:0]  GEAR_RESET  = 17'd65536;

	localparam logic [CFG_ADDR_W-1:0] REG_ENCODER_BITS = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_GEAR_RECIP   = 1'b1;

	localparam logic [BYTE_W-1:0] CMD_STOP       = 8'h80;
	localparam logic [BYTE_W-1:0] CMD_START      = 8'h88;
	localparam logic [BYTE_W-1:0] CMD_MOTION_LO  = 8'hA0;
	localparam logic [BYTE_W-1:0] CMD_MOTION_HI  = 8'hA8;
	localparam logic [BYTE_W-1:0] CMD_STATE      = 8'h9C;
	localparam logic [BYTE_W-1:0] CMD_ENCODER    = 8'h90;
	localparam logic [BYTE_W-1:0] CMD_MULTITURN  = 8'h92;
	localparam logic [BYTE_W-1:0] CMD_ERROR_A    = 8'h9A;
	localparam logic [BYTE_W-1:0] CMD_ERROR_B    = 8'h9B;
	localparam logic [BYTE_W-1:0] CMD_PID        = 8'h30;
	localparam logic [BYTE_W-1:0] TOP_NEG_MARK   = 8'hFF;

	typedef enum logic [2:0] {
		KIND_UNKNOWN,
		KIND_STOP,
		KIND_START,
		KIND_MOTION,
		KIND_ENCODER,
		KIND_MULTITURN,
		KIND_ERROR,
		KIND_PID
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ENC,
		ST_STEP,
		ST_MTURN,
		ST_DONE
	} sfd_state_t;

	typedef enum logic [1:0] {
		MT_IDLE,
		MT_MUL,
		MT_DIV,
		MT_FIX
	} mt_state_t;

	typedef struct packed {
		logic start;
		logic neg;
	} mt_ctl_t;

	// raw * 92160 / 2^bits, half rounded up; bits clamped to 14..16
	function automatic logic [ANG_W-1:0] sfd_scale(input logic [16:0] raw,
		input logic [EBITS_W-1:0] ebits);
		logic signed [22:0] p;
		logic signed [22:0] r;
		p = signed'({{6{raw[16]}}, raw}) * 23'sd45;
		if (ebits <= 5'd14) begin
			r = (p + 23'sd4) >>> 3;
		end else if (ebits == 5'd15) begin
			r = (p + 23'sd8) >>> 4;
		end else begin
			r = (p + 23'sd16) >>> 5;
		end
		return r[ANG_W-1:0];
	endfunction

endpackage

// ----- rtl/core/sfd_mturn.sv -----
// ----------------------------------------------------------------------------
// sfd_mturn
// bit-serial multi-turn scaler: count * gear / 25600, saturated, and mod 360 deg
// ----------------------------------------------------------------------------
module sfd_mturn #(
	parameter int TOTAL_WIDTH = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfd_pkg::mt_ctl_t              ctl,
	input  logic [sfd_pkg::FRAME_W-1:0]   count,
	input  logic [sfd_pkg::GEAR_W-1:0]    gear,
	output logic                          done,
	output logic [TOTAL_WIDTH-1:0]        total,
	output logic [sfd_pkg::MOD_W-1:0]     angle
);
	import sfd_pkg::*;

	mt_state_t            state_q, state_nxt;
	logic [PCNT_W-1:0]    cnt_q;
	logic                 done_q;
	logic                 neg_q;
	logic [PROD_W-1:0]    mcand_q;
	logic [GEAR_W-1:0]    mplier_q;
	logic [PROD_W-1:0]    prod_q;
	logic [PROD_W-1:0]    quot_q;
	logic [REM_W-1:0]     rem_q;
	logic [MOD_W-1:0]     mod_q;
	logic [TOTAL_WIDTH-1:0] total_q;
	logic [MOD_W-1:0]     angle_q;

	logic [FRAME_W-1:0]   mag;
	logic [REM_W:0]       rem_try;
	logic                 q_bit;
	logic [REM_W-1:0]     rem_nxt;
	logic [MOD_W:0]       mod_try;
	logic [MOD_W-1:0]     mod_nxt;
	logic                 hi;
	logic [TOTAL_WIDTH-1:0] low;
	logic [TOTAL_WIDTH-1:0] total_nxt;
	logic [MOD_W-1:0]     angle_nxt;

	// negative counts come as two's complement over 56 bits
	assign mag = ctl.neg ? (~count + FRAME_W'(1)) : count;

	// one quotient bit per cycle, remainder stays below the divisor
	assign rem_try = {rem_q, prod_q[PROD_W-1]};
	assign q_bit   = rem_try >= (REM_W+1)'(DIVISOR);
	assign rem_nxt = q_bit ? REM_W'(rem_try - (REM_W+1)'(DIVISOR)) : REM_W'(rem_try);

	// quotient mod full turn, built from the same bit stream
	assign mod_try = {mod_q, q_bit};
	assign mod_nxt = (mod_try >= (MOD_W+1)'(FULL_TURN_Q8)) ?
		MOD_W'(mod_try - (MOD_W+1)'(FULL_TURN_Q8)) : MOD_W'(mod_try);

	assign hi  = |quot_q[PROD_W-1:TOTAL_WIDTH-1];
	assign low = quot_q[TOTAL_WIDTH-1:0];

	always_comb begin
		if (neg_q) begin
			total_nxt = hi ? {1'b1, {(TOTAL_WIDTH-1){1'b0}}} : (~low + TOTAL_WIDTH'(1));
			angle_nxt = (mod_q == '0) ? '0 : MOD_W'(MOD_W'(FULL_TURN_Q8) - mod_q);
		end else begin
			total_nxt = hi ? {1'b0, {(TOTAL_WIDTH-1){1'b1}}} : low;
			angle_nxt = mod_q;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			MT_IDLE: if (ctl.start) state_nxt = MT_MUL;
			MT_MUL:  if (cnt_q == '0) state_nxt = MT_DIV;
			MT_DIV:  if (cnt_q == '0) state_nxt = MT_FIX;
			MT_FIX:  state_nxt = MT_IDLE;
			default: state_nxt = MT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MT_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == MT_FIX);
			if (state_q == MT_IDLE && ctl.start) begin
				cnt_q <= PCNT_W'(GEAR_W-1);
			end else if (state_q == MT_MUL && cnt_q == '0) begin
				cnt_q <= PCNT_W'(PROD_W-1);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - PCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MT_IDLE: begin
				if (ctl.start) begin
					neg_q    <= ctl.neg;
					mcand_q  <= PROD_W'(mag);
					mplier_q <= gear;
					prod_q   <= PROD_W'(ROUND_HALF);
					rem_q    <= '0;
					mod_q    <= '0;
				end
			end
			MT_MUL: begin
				if (mplier_q[0]) prod_q <= prod_q + mcand_q;
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[GEAR_W-1:1]};
			end
			MT_DIV: begin
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				quot_q <= {quot_q[PROD_W-2:0], q_bit};
				rem_q  <= rem_nxt;
				mod_q  <= mod_nxt;
			end
			MT_FIX: begin
				total_q <= total_nxt;
				angle_q <= angle_nxt;
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign total = total_q;
	assign angle = angle_q;

endmodule

// ----- rtl/core/servo_feedback_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// servo_feedback_frame_decoder_core
// decodes one 8-byte motor reply frame per word and streams all held values
// ----------------------------------------------------------------------------
// latency from input accept to result valid runs through the states idle, decode and
//   done; motion frames add the step state (state frames do not), encoder frames
//   the three lanes and multi-turn frames the wait on the bit-serial unit (17
//   multiply steps plus 73 divide steps); a new frame is taken only back in idle
// the encoder frame runs its three angles through one shared scaler, one a cycle
// reset: asynchronous, clears every held value, encoder_bits to 16, gear to 1.0
module servo_feedback_frame_decoder_core #(
	parameter int TOTAL_WIDTH = 48,
	localparam int FIELD_W = 148 + TOTAL_WIDTH,
	localparam int OUT_W = ((FIELD_W + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// frame in
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sfd_pkg::FRAME_W-1:0]      s_tdata,   // byte_1 .. byte_7
	input  logic [sfd_pkg::BYTE_W-1:0]       s_tuser,   // req_type
	// decoded result out
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// temperature, current_ma, speed_dps, angle_q8, total_angle_q8,
	// encoder_q8, encoder_raw_q8, encoder_offset_q8, voltage_dv, error_bits,
	// sticky_flags, zero pad
	output logic [OUT_W-1:0]                 m_tdata,
	output logic [2:0]                       m_tuser,   // frame_kind
	// register writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sfd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [sfd_pkg::GEAR_W-1:0]       cfg_data
);
	import sfd_pkg::*;

	sfd_state_t              state_q, state_nxt;
	logic [BYTE_W-1:0]       cmd_q;
	logic [FRAME_W-1:0]      frame_q;
	logic [1:0]              lane_q;
	kind_t                   kind_q;
	logic signed [DELTA_W-1:0] delta_q;

	// config registers
	logic [EBITS_W-1:0]      ebits_q;
	logic [GEAR_W-1:0]       gear_q;

	// held values
	logic [BYTE_W-1:0]       temp_q;
	logic [CUR_W-1:0]        current_q;
	logic [HALF_W-1:0]       speed_q;
	logic [ANG_W-1:0]        angle_q;
	logic [TOTAL_WIDTH-1:0]  total_q;
	logic [ANG_W-1:0]        enc_q [3];
	logic [HALF_W-1:0]       volt_q;
	logic [BYTE_W-1:0]       err_q;
	logic [FLAG_W-1:0]       flag_q;

	// output register
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;
	kind_t                   out_kind_q;

	kind_t                   kind_dec;
	logic                    step_sel;
	logic                    push;
	logic [16:0]             scale_raw;
	logic [ANG_W-1:0]        scaled;
	logic signed [DELTA_W-1:0] delta_raw;
	logic signed [DELTA_W-1:0] delta_wrap;
	logic signed [TOTAL_WIDTH:0] sum;
	logic [TOTAL_WIDTH-1:0]  total_sat;

	mt_ctl_t                 mt_ctl;
	logic                    mt_done;
	logic [TOTAL_WIDTH-1:0]  mt_total;
	logic [MOD_W-1:0]        mt_angle;

	assign cfg_ready = 1'b1;

	// command byte to frame kind
	always_comb begin
		unique case (cmd_q) inside
			CMD_STOP:                       kind_dec = KIND_STOP;
			CMD_START:                      kind_dec = KIND_START;
			[CMD_MOTION_LO:CMD_MOTION_HI],
			CMD_STATE:                      kind_dec = KIND_MOTION;
			CMD_ENCODER:                    kind_dec = KIND_ENCODER;
			CMD_MULTITURN:                  kind_dec = KIND_MULTITURN;
			CMD_ERROR_A, CMD_ERROR_B:       kind_dec = KIND_ERROR;
			CMD_PID:                        kind_dec = KIND_PID;
			default:                        kind_dec = KIND_UNKNOWN;
		endcase
	end

	// shared scaler: motion angle is signed bytes 6/7, encoder lanes are
	// unsigned and always sit at bytes 2/3 of the shifting frame
	assign scale_raw = (state_q == ST_ENC) ? {1'b0, frame_q[23:8]} :
		{frame_q[55], frame_q[55:40]};
	assign scaled = sfd_scale(scale_raw, ebits_q);

	// angle step, wrapped into one half turn either way
	assign delta_raw = signed'({{(DELTA_W-ANG_W){scaled[ANG_W-1]}}, scaled}) -
		signed'({{(DELTA_W-ANG_W){angle_q[ANG_W-1]}}, angle_q});
	always_comb begin
		if (delta_raw > DELTA_W'(HALF_TURN_Q8)) begin
			delta_wrap = delta_raw - DELTA_W'(FULL_TURN_Q8);
		end else if (delta_raw < -signed'(DELTA_W'(HALF_TURN_Q8))) begin
			delta_wrap = delta_raw + DELTA_W'(FULL_TURN_Q8);
		end else begin
			delta_wrap = delta_raw;
		end
	end

	// saturating multi-turn accumulate
	assign sum = signed'({total_q[TOTAL_WIDTH-1], total_q}) + (TOTAL_WIDTH+1)'(delta_q);
	always_comb begin
		if (sum[TOTAL_WIDTH] != sum[TOTAL_WIDTH-1]) begin
			total_sat = sum[TOTAL_WIDTH] ? {1'b1, {(TOTAL_WIDTH-1){1'b0}}} :
				{1'b0, {(TOTAL_WIDTH-1){1'b1}}};
		end else begin
			total_sat = sum[TOTAL_WIDTH-1:0];
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_nxt = ST_DECODE;
			ST_DECODE: begin
				case (kind_dec)
					KIND_MOTION:    state_nxt = step_sel ? ST_STEP : ST_DONE;
					KIND_ENCODER:   state_nxt = ST_ENC;
					KIND_MULTITURN: state_nxt = ST_MTURN;
					default:        state_nxt = ST_DONE;
				endcase
			end
			ST_ENC:   if (lane_q == 2'd2) state_nxt = ST_DONE;
			ST_STEP:  state_nxt = ST_DONE;
			ST_MTURN: if (mt_done) state_nxt = ST_DONE;
			ST_DONE:  if (!out_valid_q || m_tready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		step_sel     = (cmd_q != CMD_STATE);
		mt_ctl.start = (state_q == ST_DECODE) && (kind_dec == KIND_MULTITURN);
		mt_ctl.neg   = (frame_q[55:48] == TOP_NEG_MARK);
		push         = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	end

	sfd_mturn #(
		.TOTAL_WIDTH(TOTAL_WIDTH)
	) u_mturn (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mt_ctl),
		.count  (frame_q),
		.gear   (gear_q),
		.done   (mt_done),
		.total  (mt_total),
		.angle  (mt_angle)
	);

	// control, config and held values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lane_q      <= '0;
			out_valid_q <= 1'b0;
			ebits_q     <= EBITS_RESET;
			gear_q      <= GEAR_RESET;
			temp_q      <= '0;
			current_q   <= '0;
			speed_q     <= '0;
			angle_q     <= '0;
			total_q     <= '0;
			enc_q[0]    <= '0;
			enc_q[1]    <= '0;
			enc_q[2]    <= '0;
			volt_q      <= '0;
			err_q       <= '0;
			flag_q      <= '0;
		end else begin
			state_q <= state_nxt;

			if (cfg_valid) begin
				case (cfg_addr)
					REG_ENCODER_BITS: ebits_q <= cfg_data[EBITS_W-1:0];
					REG_GEAR_RECIP:   gear_q  <= cfg_data;
					default: ;
				endcase
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_DECODE: begin
					lane_q <= '0;
					case (kind_dec)
						KIND_STOP:      flag_q[0] <= 1'b1;
						KIND_START:     flag_q[1] <= 1'b1;
						KIND_MULTITURN: flag_q[3] <= 1'b1;
						KIND_MOTION: begin
							temp_q    <= frame_q[7:0];
							current_q <= {frame_q[23:8], 4'b0000};
							speed_q   <= frame_q[39:24];
							angle_q   <= scaled;
						end
						KIND_ERROR: begin
							flag_q[2] <= 1'b1;
							temp_q    <= frame_q[7:0];
							volt_q    <= frame_q[31:16];
							err_q     <= frame_q[55:48];
						end
						default: ;
					endcase
				end
				ST_ENC: begin
					// the three angles shift in from the top, one per cycle
					enc_q[0] <= enc_q[1];
					enc_q[1] <= enc_q[2];
					enc_q[2] <= scaled;
					lane_q   <= lane_q + 2'd1;
				end
				ST_STEP: total_q <= total_sat;
				ST_MTURN: begin
					if (mt_done) begin
						total_q <= mt_total;
						angle_q <= ANG_W'(mt_angle);
					end
				end
				default: ;
			endcase
		end
	end

	// frame capture and payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_q   <= s_tuser;
			frame_q <= s_tdata;
		end else if (state_q == ST_ENC) begin
			frame_q <= {16'h0000, frame_q[FRAME_W-1:16]};
		end
		if (state_q == ST_DECODE) begin
			kind_q  <= kind_dec;
			delta_q <= delta_wrap;
		end
		if (push) begin
			out_kind_q <= kind_q;
			out_data_q <= OUT_W'({flag_q, err_q, volt_q, enc_q[2], enc_q[1], enc_q[0],
				total_q, angle_q, speed_q, current_q, temp_q});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

`ifndef SYNTHESIS
	// sticky flags only ever gain bits
	a_flags_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (($past(flag_q) & ~flag_q) == '0))
		else $error("sticky flag cleared");

	// a new result only appears after the done state
	a_push_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result pushed outside done state");

	// the multi-turn unit reports only while it is awaited
	a_mt_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mt_done |-> (state_q == ST_MTURN))
		else $error("multi-turn done while not waiting");

	// wrapped multi-turn angle stays inside one turn
	a_mt_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		mt_done |-> (mt_angle < MOD_W'(FULL_TURN_Q8)))
		else $error("multi-turn angle out of range");
`endif

endmodule
